// ===== hw/rtl/mvna_pkg.sv =====
// Shared types, constants and helpers for the vertex normal averaging block.
`default_nettype none
package mvna_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int IDX_W        = 12;
    // Only indices that the 12-bit fields can name need storage.
    localparam int DEPTH        = (MAX_VERTICES < (1 << IDX_W)) ? MAX_VERTICES : (1 << IDX_W);
    localparam int ADDR_W       = $clog2(DEPTH);

    localparam int CMDQ_DEPTH   = 4;
    localparam int CMDQ_AW      = $clog2(CMDQ_DEPTH);

    localparam int NV_W         = 36;   // normalizer component width

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TRI   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [1:0]         op;
        t_idx               vertex_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        t_idx               corner_a;
        t_idx               corner_b;
        t_idx               corner_c;
    } t_in_item;

    typedef struct packed {
        t_idx               answered_index;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } t_out_item;

    // Classified request handed from front to back.
    typedef struct packed {
        logic     idx_ok;
        t_in_item item;
    } t_cmd;

    typedef logic signed [NV_W-1:0] t_ncomp;

    typedef struct packed {
        t_ncomp x;
        t_ncomp y;
        t_ncomp z;
    } t_nvec;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_unit;

    function automatic logic in_range(input t_idx idx);
        return int'(idx) < MAX_VERTICES;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mvna_front.sv =====
// Front end: accepts requests, drops the ones that do nothing, queues the rest.
`default_nettype none
module mvna_front (
    input  mvna_pkg::t_in_item i_item,
    input  logic               i_push,
    input  logic               i_q_full,
    input  logic               i_clearing,
    output logic               o_full,
    output logic               o_q_push,
    output mvna_pkg::t_cmd     o_cmd
);
    import mvna_pkg::*;

    logic keep;

    always_comb begin
        case (i_item.op)
            OP_LOAD:  keep = in_range(i_item.vertex_index);
            OP_TRI:   keep = in_range(i_item.corner_a) && in_range(i_item.corner_b)
                             && in_range(i_item.corner_c);
            OP_QUERY: keep = 1'b1;
            default:  keep = 1'b0;
        endcase
    end

    assign o_full       = i_q_full || i_clearing;
    assign o_q_push     = i_push && !o_full && keep;
    assign o_cmd.idx_ok = in_range(i_item.vertex_index);
    assign o_cmd.item   = i_item;

endmodule
`default_nettype wire

// ===== hw/rtl/mvna_cmd_fifo.sv =====
// Short request queue between front and back.
`default_nettype none
module mvna_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mvna_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output mvna_pkg::t_cmd o_cmd,
    output logic           o_full,
    output logic           o_empty
);
    import mvna_pkg::*;

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wp;
    logic [CMDQ_AW-1:0] r_rp;
    logic [CMDQ_AW:0]   r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mvna_norm.sv =====
// Iterative vector normalizer to Q1.14: shift to range, sum of squares, bit search.
`default_nettype none
module mvna_norm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  mvna_pkg::t_nvec i_vec,
    output logic            o_done,
    output mvna_pkg::t_unit o_res
);
    import mvna_pkg::*;

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_TOP   = 3'd1;
    localparam logic [2:0] N_SHIFT = 3'd2;
    localparam logic [2:0] N_SQ    = 3'd3;
    localparam logic [2:0] N_LIM   = 3'd4;
    localparam logic [2:0] N_T     = 3'd5;
    localparam logic [2:0] N_CMP   = 3'd6;

    logic [2:0]         r_state;
    logic [NV_W-1:0]    r_mag [3];
    logic [2:0]         r_neg;
    logic [NV_W-1:0]    r_top;
    logic [31:0]        r_s;
    logic [59:0]        r_lim;
    logic [31:0]        r_tsq;
    logic [14:0]        r_q;
    logic [3:0]         r_bit;
    logic [1:0]         r_k;
    logic signed [15:0] r_res [3];
    logic               r_done;

    logic [29:0]        sq;
    logic [14:0]        cand;
    logic [15:0]        t;
    logic [63:0]        prod;
    logic [14:0]        q_fin;
    logic [NV_W-1:0]    top_c;
    logic signed [15:0] res_c;

    function automatic logic [NV_W-1:0] mag_of(input t_ncomp v);
        return v[NV_W-1] ? NV_W'(-v) : NV_W'(v);
    endfunction

    always_comb begin
        sq    = r_mag[r_k][14:0] * r_mag[r_k][14:0];
        cand  = r_q | (15'd1 << r_bit);
        t     = {cand, 1'b0} - 16'd1;
        prod  = 64'(r_tsq) * 64'(r_s);
        q_fin = (prod <= {4'b0, r_lim}) ? cand : r_q;
        res_c = r_neg[r_k] ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
        top_c = r_mag[0];
        if (r_mag[1] > top_c) begin
            top_c = r_mag[1];
        end
        if (r_mag[2] > top_c) begin
            top_c = r_mag[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
            r_k     <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_mag[0] <= mag_of(i_vec.x);
                        r_mag[1] <= mag_of(i_vec.y);
                        r_mag[2] <= mag_of(i_vec.z);
                        r_neg    <= {i_vec.z[NV_W-1], i_vec.y[NV_W-1], i_vec.x[NV_W-1]};
                        r_state  <= N_TOP;
                    end
                end
                N_TOP: begin
                    r_top <= top_c;
                    if (top_c == '0) begin
                        r_res[0] <= '0;
                        r_res[1] <= '0;
                        r_res[2] <= '0;
                        r_done   <= 1'b1;
                        r_state  <= N_IDLE;
                    end else begin
                        r_state <= N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    // bring the largest magnitude into [16384, 32767]
                    if (r_top[NV_W-1:15] != '0) begin
                        r_top    <= r_top >> 1;
                        r_mag[0] <= r_mag[0] >> 1;
                        r_mag[1] <= r_mag[1] >> 1;
                        r_mag[2] <= r_mag[2] >> 1;
                    end else if (!r_top[14]) begin
                        r_top    <= r_top << 1;
                        r_mag[0] <= r_mag[0] << 1;
                        r_mag[1] <= r_mag[1] << 1;
                        r_mag[2] <= r_mag[2] << 1;
                    end else begin
                        r_s     <= '0;
                        r_k     <= '0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    r_s <= r_s + 32'(sq);
                    if (r_k == 2'd2) begin
                        r_k     <= '0;
                        r_state <= N_LIM;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                N_LIM: begin
                    r_lim   <= {sq, 30'b0};
                    r_q     <= '0;
                    r_bit   <= 4'd14;
                    r_state <= N_T;
                end
                N_T: begin
                    r_tsq   <= t * t;
                    r_state <= N_CMP;
                end
                N_CMP: begin
                    // keep the candidate bit when (2q-1)^2 * S <= m^2 * 2^30
                    r_q <= q_fin;
                    if (r_bit == '0) begin
                        r_res[r_k] <= res_c;
                        if (r_k == 2'd2) begin
                            r_done  <= 1'b1;
                            r_state <= N_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= N_LIM;
                        end
                    end else begin
                        r_bit   <= r_bit - 1'b1;
                        r_state <= N_T;
                    end
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_res.x = r_res[0];
    assign o_res.y = r_res[1];
    assign o_res.z = r_res[2];

endmodule
`default_nettype wire

// ===== hw/rtl/mvna_back.sv =====
// Back end: position and sum memories, face vector, accumulation, queries.
`default_nettype none
module mvna_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mvna_pkg::t_cmd      i_cmd,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    output logic                o_clearing,
    output mvna_pkg::t_out_item o_result,
    output logic                o_empty,
    input  logic                i_pop
);
    import mvna_pkg::*;

    localparam logic [4:0] B_CLEAR  = 5'd0;
    localparam logic [4:0] B_IDLE   = 5'd1;
    localparam logic [4:0] B_RDA    = 5'd2;
    localparam logic [4:0] B_RDB    = 5'd3;
    localparam logic [4:0] B_RDC    = 5'd4;
    localparam logic [4:0] B_DIFF   = 5'd5;
    localparam logic [4:0] B_X0     = 5'd6;
    localparam logic [4:0] B_X1     = 5'd7;
    localparam logic [4:0] B_X2     = 5'd8;
    localparam logic [4:0] B_X3     = 5'd9;
    localparam logic [4:0] B_NSTART = 5'd10;
    localparam logic [4:0] B_NWAIT  = 5'd11;
    localparam logic [4:0] B_SRD    = 5'd12;
    localparam logic [4:0] B_SWR    = 5'd13;
    localparam logic [4:0] B_QRD    = 5'd14;
    localparam logic [4:0] B_QNORM  = 5'd15;
    localparam logic [4:0] B_QWAIT  = 5'd16;
    localparam logic [4:0] B_QOUT   = 5'd17;

    logic [4:0]         r_state;
    logic [ADDR_W-1:0]  r_clr_addr;
    t_cmd               r_cmd;
    logic [1:0]         r_j;

    logic [47:0]        r_pos_mem [DEPTH];
    logic [59:0]        r_sum_mem [DEPTH];
    logic [47:0]        r_pos_rd;
    logic [59:0]        r_sum_rd;
    logic [47:0]        r_pa;
    logic [47:0]        r_pb;

    logic signed [16:0] r_d1x, r_d1y, r_d1z, r_d2x, r_d2y, r_d2z;
    logic signed [33:0] r_p1, r_p2;
    logic signed [34:0] r_fx, r_fy, r_fz;
    t_unit              r_n;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               pos_rd_en;
    logic [ADDR_W-1:0]  pos_rd_addr;
    logic               pos_wr_en;
    logic               sum_rd_en;
    logic [ADDR_W-1:0]  sum_rd_addr;
    logic               sum_wr_en;
    logic [ADDR_W-1:0]  sum_wr_addr;
    logic [59:0]        sum_wr_data;
    logic [ADDR_W-1:0]  corner_addr;
    logic [ADDR_W-1:0]  cmd_addr;

    logic signed [16:0] ma1, mb1, ma2, mb2;
    logic signed [33:0] mp1, mp2;
    logic signed [34:0] fdiff;

    logic               norm_start;
    t_nvec              norm_vec;
    logic               norm_done;
    t_unit              norm_res;

    logic               out_load;

    function automatic logic [19:0] sat_add(input logic [19:0] s, input logic signed [15:0] n);
        logic signed [20:0] r;
        r = $signed({s[19], s}) + $signed({{5{n[15]}}, n});
        case (r[20:19])
            2'b01:   return 20'h7FFFF;
            2'b10:   return 20'h80000;
            default: return r[19:0];
        endcase
    endfunction

    function automatic logic signed [16:0] sub16(input logic [15:0] a, input logic [15:0] b);
        return $signed({a[15], a}) - $signed({b[15], b});
    endfunction

    function automatic t_ncomp sx20(input logic [19:0] v);
        return t_ncomp'($signed(v));
    endfunction

    assign cmd_addr = r_cmd.item.vertex_index[ADDR_W-1:0];

    always_comb begin
        case (r_j)
            2'd0:    corner_addr = r_cmd.item.corner_a[ADDR_W-1:0];
            2'd1:    corner_addr = r_cmd.item.corner_b[ADDR_W-1:0];
            default: corner_addr = r_cmd.item.corner_c[ADDR_W-1:0];
        endcase
    end

    assign o_q_pop    = (r_state == B_IDLE) && !i_q_empty;
    assign o_clearing = (r_state == B_CLEAR);
    assign out_load   = (r_state == B_QOUT) && (!r_out_valid || i_pop);

    // memory port control
    always_comb begin
        pos_rd_en   = 1'b0;
        pos_rd_addr = r_cmd.item.corner_a[ADDR_W-1:0];
        case (r_state)
            B_RDA: pos_rd_en = 1'b1;
            B_RDB: begin
                pos_rd_en   = 1'b1;
                pos_rd_addr = r_cmd.item.corner_b[ADDR_W-1:0];
            end
            B_RDC: begin
                pos_rd_en   = 1'b1;
                pos_rd_addr = r_cmd.item.corner_c[ADDR_W-1:0];
            end
            default: pos_rd_en = 1'b0;
        endcase

        pos_wr_en = o_q_pop && (i_cmd.item.op == OP_LOAD);

        sum_rd_en   = (r_state == B_SRD) || (r_state == B_QRD);
        sum_rd_addr = (r_state == B_QRD) ? cmd_addr : corner_addr;

        sum_wr_en   = 1'b0;
        sum_wr_addr = r_clr_addr;
        sum_wr_data = '0;
        if (r_state == B_CLEAR) begin
            sum_wr_en = 1'b1;
        end else if (pos_wr_en) begin
            sum_wr_en   = 1'b1;
            sum_wr_addr = i_cmd.item.vertex_index[ADDR_W-1:0];
        end else if (r_state == B_SWR) begin
            sum_wr_en   = 1'b1;
            sum_wr_addr = corner_addr;
            sum_wr_data = {sat_add(r_sum_rd[59:40], r_n.z),
                           sat_add(r_sum_rd[39:20], r_n.y),
                           sat_add(r_sum_rd[19:0],  r_n.x)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pos_wr_en) begin
            r_pos_mem[i_cmd.item.vertex_index[ADDR_W-1:0]] <=
                {i_cmd.item.pos_z, i_cmd.item.pos_y, i_cmd.item.pos_x};
        end
        if (pos_rd_en) begin
            r_pos_rd <= r_pos_mem[pos_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_wr_en) begin
            r_sum_mem[sum_wr_addr] <= sum_wr_data;
        end
        if (sum_rd_en) begin
            r_sum_rd <= r_sum_mem[sum_rd_addr];
        end
    end

    // shared pair of multipliers for the cross product
    always_comb begin
        case (r_state)
            B_X0: begin
                ma1 = r_d1y; mb1 = r_d2z; ma2 = r_d1z; mb2 = r_d2y;
            end
            B_X1: begin
                ma1 = r_d1z; mb1 = r_d2x; ma2 = r_d1x; mb2 = r_d2z;
            end
            default: begin
                ma1 = r_d1x; mb1 = r_d2y; ma2 = r_d1y; mb2 = r_d2x;
            end
        endcase
        mp1   = ma1 * mb1;
        mp2   = ma2 * mb2;
        fdiff = $signed({r_p1[33], r_p1}) - $signed({r_p2[33], r_p2});
    end

    always_comb begin
        norm_start = (r_state == B_NSTART) || (r_state == B_QNORM);
        if (r_state == B_NSTART) begin
            norm_vec.x = t_ncomp'(r_fx);
            norm_vec.y = t_ncomp'(r_fy);
            norm_vec.z = t_ncomp'(r_fz);
        end else if (r_cmd.idx_ok) begin
            norm_vec.x = sx20(r_sum_rd[19:0]);
            norm_vec.y = sx20(r_sum_rd[39:20]);
            norm_vec.z = sx20(r_sum_rd[59:40]);
        end else begin
            norm_vec = '0;
        end
    end

    mvna_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_vec   (norm_vec),
        .o_done  (norm_done),
        .o_res   (norm_res)
    );

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_RDB:  r_pa <= r_pos_rd;
            B_RDC:  r_pb <= r_pos_rd;
            B_DIFF: begin
                r_d1x <= sub16(r_pa[15:0],  r_pb[15:0]);
                r_d1y <= sub16(r_pa[31:16], r_pb[31:16]);
                r_d1z <= sub16(r_pa[47:32], r_pb[47:32]);
                r_d2x <= sub16(r_pa[15:0],  r_pos_rd[15:0]);
                r_d2y <= sub16(r_pa[31:16], r_pos_rd[31:16]);
                r_d2z <= sub16(r_pa[47:32], r_pos_rd[47:32]);
            end
            default: begin
            end
        endcase
        if (r_state == B_X0 || r_state == B_X1 || r_state == B_X2) begin
            r_p1 <= mp1;
            r_p2 <= mp2;
        end
        if (r_state == B_X1) begin
            r_fx <= fdiff;
        end
        if (r_state == B_X2) begin
            r_fy <= fdiff;
        end
        if (r_state == B_X3) begin
            r_fz <= fdiff;
        end
        if (norm_done) begin
            r_n <= norm_res;
        end
        if (o_q_pop) begin
            r_cmd <= i_cmd;
        end
        if (out_load) begin
            r_out.answered_index <= r_cmd.item.vertex_index;
            r_out.normal_x       <= r_n.x;
            r_out.normal_y       <= r_n.y;
            r_out.normal_z       <= r_n.z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(DEPTH-1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (o_q_pop) begin
                        case (i_cmd.item.op)
                            OP_TRI:   r_state <= B_RDA;
                            OP_QUERY: r_state <= B_QRD;
                            default:  r_state <= B_IDLE;
                        endcase
                    end
                end
                B_RDA:    r_state <= B_RDB;
                B_RDB:    r_state <= B_RDC;
                B_RDC:    r_state <= B_DIFF;
                B_DIFF:   r_state <= B_X0;
                B_X0:     r_state <= B_X1;
                B_X1:     r_state <= B_X2;
                B_X2:     r_state <= B_X3;
                B_X3:     r_state <= B_NSTART;
                B_NSTART: r_state <= B_NWAIT;
                B_NWAIT: begin
                    if (norm_done) begin
                        r_j     <= '0;
                        r_state <= B_SRD;
                    end
                end
                B_SRD:    r_state <= B_SWR;
                B_SWR: begin
                    if (r_j == 2'd2) begin
                        r_state <= B_IDLE;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= B_SRD;
                    end
                end
                B_QRD:    r_state <= B_QNORM;
                B_QNORM:  r_state <= B_QWAIT;
                B_QWAIT: begin
                    if (norm_done) begin
                        r_state <= B_QOUT;
                    end
                end
                B_QOUT: begin
                    if (out_load) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_result = r_out;
    assign o_empty  = !r_out_valid;

endmodule
`default_nettype wire

// ===== hw/rtl/mesh_vertex_normal_average.sv =====
// Vertex normal averaging of unit face normals: top level.
//
// Requests enter a four-deep queue, and the back end carries them out one at
// a time. A triangle and a query each use the normalizer, a shared iterative
// unit. It first finds the largest magnitude and scales the vector (one bit
// per cycle), then forms the sum of squares and runs a 15-step bit search for
// each of the three components, and then signals done. A zero vector skips
// the scaling and the search. After reset the block clears all 4096 entries
// of its normal sums, one entry a cycle, and holds full high until done. A
// result is held in one output register. A query that finishes while the
// previous answer is still unpopped waits in its last step. Meanwhile the
// queue keeps taking requests until it fills.
`default_nettype none
module mesh_vertex_normal_average (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  mvna_pkg::t_in_item  i_item,
    output logic                o_empty,
    input  logic                i_pop,
    output mvna_pkg::t_out_item o_result
);
    import mvna_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    logic clearing;
    t_cmd front_cmd;
    t_cmd back_cmd;

    mvna_front u_front (
        .i_item     (i_item),
        .i_push     (i_push),
        .i_q_full   (q_full),
        .i_clearing (clearing),
        .o_full     (o_full),
        .o_q_push   (q_push),
        .o_cmd      (front_cmd)
    );

    mvna_cmd_fifo u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (back_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mvna_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (back_cmd),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_result   (o_result),
        .o_empty    (o_empty),
        .i_pop      (i_pop)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/mvna_checker.sv =====
// Port-level checker for the vertex normal averaging block, with its bind.
`default_nettype none
module mvna_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_push,
    input logic                o_full,
    input mvna_pkg::t_in_item  i_item,
    input logic                o_empty,
    input logic                i_pop,
    input mvna_pkg::t_out_item o_result
);
    import mvna_pkg::*;

    // coming out of reset: nothing to pop, and no request taken while clearing
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty && o_full)
        else $error("block not empty and full after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_result))
        else $error("waiting result changed before pop");

    a_drain_by_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_empty) |-> $past(i_pop))
        else $error("result vanished without pop");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> o_result.normal_x <= 16'sd16384 && o_result.normal_x >= -16'sd16384
                  && o_result.normal_y <= 16'sd16384 && o_result.normal_y >= -16'sd16384
                  && o_result.normal_z <= 16'sd16384 && o_result.normal_z >= -16'sd16384)
        else $error("normal component outside unit range");

endmodule

bind mesh_vertex_normal_average mvna_checker u_mvna_checker (.*);
`default_nettype wire

// ===== tb/sv/mvna_checker.sv =====
// Checker for the vertex normal block: predicts query answers and compares them.
`default_nettype none
module mvna_scoreboard (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_full,
    input  mvna_pkg::t_in_item  i_item,
    input  logic                i_empty,
    input  logic                i_pop,
    input  mvna_pkg::t_out_item i_result,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mvna_pkg::*;

    localparam longint SUM_HI = 524287;
    localparam longint SUM_LO = -524288;

    typedef longint t_vec3 [3];

    t_vec3     vert_pos [MAX_VERTICES];
    t_vec3     vert_sum [MAX_VERTICES];
    t_out_item answer_q [$];
    int        fails;

    assign o_fail_count = fails;
    assign o_pending    = answer_q.size();

    initial begin
        fails = 0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            vert_pos[i] = '{0, 0, 0};
            vert_sum[i] = '{0, 0, 0};
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
        fails++;
    endtask

    // Scale so the largest magnitude sits in [16384, 32767], then search each
    // Q1.14 magnitude with round-half-up against the sum of squares.
    function automatic t_vec3 unit_normal(input t_vec3 v);
        longint unsigned mag [3];
        longint unsigned top, s, lim, lo, hi, mid, t;
        t_vec3 res;
        top = 0;
        s   = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = (v[k] < 0) ? longint'(-v[k]) : longint'(v[k]);
            if (mag[k] > top) top = mag[k];
        end
        if (top == 0) return '{0, 0, 0};
        while (top >= 32768) begin
            top = top >> 1;
            for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
        end
        while (top < 16384) begin
            top = top << 1;
            for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
        end
        for (int k = 0; k < 3; k++) s += mag[k] * mag[k];
        for (int k = 0; k < 3; k++) begin
            lim = (mag[k] * mag[k]) << 30;
            lo  = 0;
            hi  = 16384;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                t   = 2 * mid - 1;
                if (t * t * s <= lim) lo = mid;
                else hi = mid - 1;
            end
            res[k] = (v[k] < 0) ? -longint'(lo) : longint'(lo);
        end
        return res;
    endfunction

    function automatic longint clamp_sum(input longint x);
        if (x > SUM_HI) return SUM_HI;
        if (x < SUM_LO) return SUM_LO;
        return x;
    endfunction

    task automatic apply_request(input t_in_item it);
        int        c [3];
        t_vec3     d1, d2, face, un;
        t_out_item ans;
        case (it.op)
            OP_LOAD: begin
                if (int'(it.vertex_index) < MAX_VERTICES) begin
                    vert_pos[it.vertex_index] = '{it.pos_x, it.pos_y, it.pos_z};
                    vert_sum[it.vertex_index] = '{0, 0, 0};
                end
            end
            OP_TRI: begin
                c = '{int'(it.corner_a), int'(it.corner_b), int'(it.corner_c)};
                if (c[0] < MAX_VERTICES && c[1] < MAX_VERTICES && c[2] < MAX_VERTICES) begin
                    for (int k = 0; k < 3; k++) begin
                        d1[k] = vert_pos[c[0]][k] - vert_pos[c[1]][k];
                        d2[k] = vert_pos[c[0]][k] - vert_pos[c[2]][k];
                    end
                    face[0] = d1[1] * d2[2] - d1[2] * d2[1];
                    face[1] = d1[2] * d2[0] - d1[0] * d2[2];
                    face[2] = d1[0] * d2[1] - d1[1] * d2[0];
                    un = unit_normal(face);
                    for (int j = 0; j < 3; j++)
                        for (int k = 0; k < 3; k++)
                            vert_sum[c[j]][k] = clamp_sum(vert_sum[c[j]][k] + un[k]);
                end
            end
            OP_QUERY: begin
                d1 = '{0, 0, 0};
                if (int'(it.vertex_index) < MAX_VERTICES) d1 = vert_sum[it.vertex_index];
                un = unit_normal(d1);
                ans.answered_index = it.vertex_index;
                ans.normal_x = 16'(un[0]);
                ans.normal_y = 16'(un[1]);
                ans.normal_z = 16'(un[2]);
                answer_q = {answer_q, ans};
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_push && !i_full) apply_request(i_item);
            if (i_pop && !i_empty) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("answer with no query waiting, index",
                                    i_result.answered_index, -1);
                end else begin
                    want = answer_q.pop_front();
                    if (i_result.answered_index !== want.answered_index)
                        report_mismatch("answered_index", i_result.answered_index,
                                        want.answered_index);
                    if (i_result.normal_x !== want.normal_x)
                        report_mismatch("normal_x", i_result.normal_x, want.normal_x);
                    if (i_result.normal_y !== want.normal_y)
                        report_mismatch("normal_y", i_result.normal_y, want.normal_y);
                    if (i_result.normal_z !== want.normal_z)
                        report_mismatch("normal_z", i_result.normal_z, want.normal_z);
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/tb_mesh_vertex_normal_average.sv =====
// Testbench top: stimulus, idle phases and verdict for the vertex normal block.
`default_nettype none
module tb_mesh_vertex_normal_average;
    timeunit 1ns;
    timeprecision 1ps;
    import mvna_pkg::*;

    localparam int RAND_ITEMS  = 1250;
    localparam int CYCLE_LIMIT = 3000000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    logic      full, empty;
    t_in_item  item = '0;
    t_out_item result;
    int        fail_count, pending;
    int        cycles = 0;
    int        send_idle_pct = 0;
    int        pop_stall_pct = 0;
    int        loaded [$];
    int        n_load = 0, n_tri = 0, n_query = 0, n_other = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    mesh_vertex_normal_average dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_push(push), .o_full(full), .i_item(item),
        .o_empty(empty), .i_pop(pop), .o_result(result)
    );

    mvna_scoreboard u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_push(push), .i_full(full), .i_item(item),
        .i_empty(empty), .i_pop(pop), .i_result(result),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("mesh_vertex_normal_average: mismatch");
            $finish;
        end
    end

    always @(negedge clk) pop <= ($urandom_range(99) >= pop_stall_pct);

    // Holds the request until accepted; random idle cycles go before it.
    task automatic send_request(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk) push <= 1'b0;
        @(negedge clk);
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
        case (it.op)
            OP_LOAD:  n_load++;
            OP_TRI:   n_tri++;
            OP_QUERY: n_query++;
            default:  n_other++;
        endcase
    endtask

    function automatic t_in_item noise_item();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    task automatic load_vertex(input int idx, input int x, input int y, input int z);
        t_in_item it;
        it = noise_item();
        it.op = OP_LOAD;
        it.vertex_index = t_idx'(idx);
        it.pos_x = 16'(x);
        it.pos_y = 16'(y);
        it.pos_z = 16'(z);
        if (!(idx inside {loaded})) loaded = {loaded, idx};
        send_request(it);
    endtask

    task automatic add_triangle(input int a, input int b, input int c);
        t_in_item it;
        it = noise_item();
        it.op = OP_TRI;
        it.corner_a = t_idx'(a);
        it.corner_b = t_idx'(b);
        it.corner_c = t_idx'(c);
        send_request(it);
    endtask

    task automatic query_vertex(input int idx);
        t_in_item it;
        it = noise_item();
        it.op = OP_QUERY;
        it.vertex_index = t_idx'(idx);
        send_request(it);
    endtask

    function automatic int pick_loaded();
        return loaded[$urandom_range(loaded.size() - 1)];
    endfunction

    initial begin
        t_in_item it;
        int r, a, b, c, burst, n;
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed: extremes, all ops, degenerate and repeated-corner faces
        load_vertex(0, 0, 0, 0);
        load_vertex(4095, 32767, -32768, 32767);
        load_vertex(1, -32768, 32767, -32768);
        load_vertex(2, 256, 0, 0);
        load_vertex(3, 0, 256, 0);
        load_vertex(5, 512, 0, 0);
        add_triangle(0, 2, 3);
        add_triangle(0, 4095, 1);
        add_triangle(0, 0, 2);
        add_triangle(2, 2, 2);
        add_triangle(0, 2, 5);
        query_vertex(0);
        query_vertex(2);
        query_vertex(4095);
        query_vertex(77);
        it = noise_item();
        it.op = 2'd3;
        send_request(it);
        load_vertex(2, 256, 0, 0);
        query_vertex(2);
        add_triangle(1, 2, 3);
        query_vertex(3);
        query_vertex(1);

        for (int i = 0; i < 24; i++)
            load_vertex($urandom_range(4095), $urandom, $urandom, $urandom);

        n = 0;
        while (n < RAND_ITEMS) begin
            case (n * 4 / RAND_ITEMS)
                0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
                1: begin send_idle_pct = 58; pop_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  pop_stall_pct = 58; end
                default: begin send_idle_pct = 11; pop_stall_pct = 11; end
            endcase
            r = $urandom_range(99);
            if (r < 2) begin
                // same face over and over can drive the sums into saturation
                a = pick_loaded(); b = pick_loaded(); c = pick_loaded();
                burst = $urandom_range(35, 45);
                repeat (burst) add_triangle(a, b, c);
                query_vertex(a);
                n += burst + 1;
            end else begin
                if (r < 8) begin
                    if ($urandom_range(99) < 60)
                        load_vertex(pick_loaded(), $urandom, $urandom, $urandom);
                    else
                        load_vertex($urandom_range(4095), $urandom, $urandom, $urandom);
                end else if (r < 62) begin
                    add_triangle(pick_loaded(), pick_loaded(), pick_loaded());
                end else if (r < 96) begin
                    query_vertex(($urandom_range(99) < 75) ? pick_loaded()
                                                          : $urandom_range(4095));
                end else begin
                    it = noise_item();
                    it.op = 2'd3;
                    send_request(it);
                end
                n++;
            end
        end
        @(negedge clk) push <= 1'b0;
        pop_stall_pct = 0;

        wait (pending == 0);
        repeat (400) @(posedge clk);
        $display("covered %0d loads, %0d triangles, %0d queries, %0d unused-op requests",
                 n_load, n_tri, n_query, n_other);
        $display("over %0d vertices, four idle/stall phases, %0d cycles",
                 loaded.size(), cycles);
        if (fail_count == 0 && pending == 0)
            $display("mesh_vertex_normal_average: match");
        else
            $display("mesh_vertex_normal_average: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/mvna_pkg.sv
hw/rtl/mvna_front.sv
hw/rtl/mvna_cmd_fifo.sv
hw/rtl/mvna_norm.sv
hw/rtl/mvna_back.sv
hw/rtl/mesh_vertex_normal_average.sv
hw/rtl/mvna_checker.sv
tb/sv/mvna_checker.sv
tb/sv/tb_mesh_vertex_normal_average.sv
